// ===== sv/asp_pkg.sv =====
// Shared types and constants of the ADC-to-servo PWM mapper.
// Holds the micro-op codes, the control word layout and the sequencer program.
// No dependencies.
package asp_pkg;

   // fixed result field widths
   localparam int ANGLE_W = 8;
   localparam int DUTY_W  = 13;
   localparam int TICKS_W = 26;

   localparam logic [ANGLE_W-1:0] MAX_DEG     = 8'd180;
   localparam logic [ANGLE_W-1:0] ANGLE_RESET = 8'd90;
   localparam logic [8:0]         ALPHA_ONE   = 9'd256;

   // duty window is 5/200 .. 25/200 of the period
   localparam int unsigned DUTY_PERIOD_PARTS = 200;
   localparam int unsigned DUTY_MIN_PARTS    = 5;
   localparam int unsigned DUTY_MAX_PARTS    = 25;
   localparam int unsigned DUTY_LO_DIV       = DUTY_PERIOD_PARTS / DUTY_MIN_PARTS;
   localparam int unsigned DUTY_HI_DIV       = DUTY_PERIOD_PARTS / DUTY_MAX_PARTS;

   // shared serial divider: 32-bit dividend, 16-bit divisor, 2 quotient bits a cycle
   localparam int DIV_W     = 32;
   localparam int DIVISOR_W = 16;
   localparam int DIV_STEPS = DIV_W / 2;
   localparam int MUL_W     = 16;

   // register reset values that do not depend on the sample width
   localparam logic [8:0]  ALPHA_RESET = 9'd51;
   localparam logic [15:0] STEPS_RESET = 16'd1000;
   localparam logic [15:0] FREQ_RESET  = 16'd50;

   typedef enum logic [2:0] {
      REG_RAW_MIN   = 3'd0,
      REG_RAW_MAX   = 3'd1,
      REG_MID_POINT = 3'd2,
      REG_DEADZONE  = 3'd3,
      REG_ALPHA     = 3'd4,
      REG_STEPS     = 3'd5,
      REG_FREQ      = 3'd6
   } csr_reg_type;

   typedef enum logic [4:0] {
      OP_NOP,
      OP_ACCEPT,
      OP_CLAMP,
      OP_MUL_REMAP,
      OP_DIV_REMAP,
      OP_SET_SCALED,
      OP_SNAP,
      OP_MUL_FRESH,
      OP_DIV_FRESH,
      OP_SET_FRESH,
      OP_MUL_PREV,
      OP_MUL_NEW,
      OP_SET_ANGLE,
      OP_DIV_LO,
      OP_SET_LO,
      OP_MUL_DUTY,
      OP_DIV_DUTY,
      OP_SET_DUTY,
      OP_ZERO_TICKS,
      OP_DIV_T1,
      OP_DIV_T2,
      OP_SET_TICKS,
      OP_EMIT
   } op_type;

   typedef enum logic [2:0] {
      COND_NEXT,
      COND_ALWAYS,
      COND_NO_REQ,
      COND_CLAMPED,
      COND_DIV_BUSY,
      COND_NO_TICKS,
      COND_RSP_BLOCKED
   } cond_type;

   localparam int STEP_W      = 5;
   localparam int UCODE_DEPTH = 2 ** STEP_W;

   typedef logic [STEP_W-1:0] step_type;

   // jump targets
   localparam step_type STEP_IDLE       = 5'd0;
   localparam step_type STEP_WAIT_REMAP = 5'd4;
   localparam step_type STEP_SNAP       = 5'd6;
   localparam step_type STEP_WAIT_FRESH = 5'd9;
   localparam step_type STEP_WAIT_LO    = 5'd15;
   localparam step_type STEP_WAIT_DUTY  = 5'd19;
   localparam step_type STEP_WAIT_T1    = 5'd23;
   localparam step_type STEP_WAIT_T2    = 5'd25;
   localparam step_type STEP_EMIT       = 5'd27;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type target;
   } ucode_type;

   // jump to target when cond holds, else fall through to the next step
   localparam ucode_type UCODE_ROM [0:UCODE_DEPTH-1] = '{
      '{OP_ACCEPT,     COND_NO_REQ,      STEP_IDLE},
      '{OP_CLAMP,      COND_CLAMPED,     STEP_SNAP},
      '{OP_MUL_REMAP,  COND_NEXT,        STEP_IDLE},
      '{OP_DIV_REMAP,  COND_NEXT,        STEP_IDLE},
      '{OP_NOP,        COND_DIV_BUSY,    STEP_WAIT_REMAP},
      '{OP_SET_SCALED, COND_NEXT,        STEP_IDLE},
      '{OP_SNAP,       COND_NEXT,        STEP_IDLE},
      '{OP_MUL_FRESH,  COND_NEXT,        STEP_IDLE},
      '{OP_DIV_FRESH,  COND_NEXT,        STEP_IDLE},
      '{OP_NOP,        COND_DIV_BUSY,    STEP_WAIT_FRESH},
      '{OP_SET_FRESH,  COND_NEXT,        STEP_IDLE},
      '{OP_MUL_PREV,   COND_NEXT,        STEP_IDLE},
      '{OP_MUL_NEW,    COND_NEXT,        STEP_IDLE},
      '{OP_SET_ANGLE,  COND_NEXT,        STEP_IDLE},
      '{OP_DIV_LO,     COND_NEXT,        STEP_IDLE},
      '{OP_NOP,        COND_DIV_BUSY,    STEP_WAIT_LO},
      '{OP_SET_LO,     COND_NEXT,        STEP_IDLE},
      '{OP_MUL_DUTY,   COND_NEXT,        STEP_IDLE},
      '{OP_DIV_DUTY,   COND_NEXT,        STEP_IDLE},
      '{OP_NOP,        COND_DIV_BUSY,    STEP_WAIT_DUTY},
      '{OP_SET_DUTY,   COND_NEXT,        STEP_IDLE},
      '{OP_ZERO_TICKS, COND_NO_TICKS,    STEP_EMIT},
      '{OP_DIV_T1,     COND_NEXT,        STEP_IDLE},
      '{OP_NOP,        COND_DIV_BUSY,    STEP_WAIT_T1},
      '{OP_DIV_T2,     COND_NEXT,        STEP_IDLE},
      '{OP_NOP,        COND_DIV_BUSY,    STEP_WAIT_T2},
      '{OP_SET_TICKS,  COND_NEXT,        STEP_IDLE},
      '{OP_EMIT,       COND_RSP_BLOCKED, STEP_EMIT},
      '{OP_NOP,        COND_ALWAYS,      STEP_IDLE},
      '{OP_NOP,        COND_ALWAYS,      STEP_IDLE},
      '{OP_NOP,        COND_ALWAYS,      STEP_IDLE},
      '{OP_NOP,        COND_ALWAYS,      STEP_IDLE}
   };

endpackage

// ===== sv/adc_to_servo_pwm_mapper_top.sv =====
// Joystick ADC to servo PWM mapper: microcoded sequencer over a shared
// multiplier and a shared 2-bit-per-cycle restoring divider.
// Depends on asp_pkg.
//
// Usage:
//  req_*  : one raw ADC sample per beat.
//  rsp_*  : one result per sample: remapped sample, filtered angle, PWM duty
//           count and half-period tick count.
//  csr_*  : register writes, index 0..6 (raw_min, raw_max, mid_point,
//           deadzone_half_width, alpha_q8, duty_steps, pwm_freq_hz); other
//           indexes are dropped. csr_ready is always high.
// Program: a sample runs the whole program from accept to result, and the next
//  sample is taken only after that result is emitted. Up to six shared-divider
//  passes plus the other program steps make up the run. Out-of-range samples
//  skip the remap division; zero duty_steps or pwm_freq_hz skips both tick
//  divisions.
// Stall: the result sits in an output register; the sequencer runs the next
//  sample meanwhile and only holds at its last step until that register frees.
// Reset: registers return to their reset values, the stored angle to 90
//  degrees, no result pending.
module adc_to_servo_pwm_mapper_top #(
   parameter int          SAMPLE_BITS = 12,
   parameter int unsigned CLOCK_HZ    = 100000000,
   localparam int IN_DATA_W  = ((SAMPLE_BITS + 7) / 8) * 8,
   localparam int OUT_DATA_W = ((SAMPLE_BITS + asp_pkg::ANGLE_W + asp_pkg::DUTY_W
                                 + asp_pkg::TICKS_W + 7) / 8) * 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [IN_DATA_W-1:0]  req_tdata,   // raw_sample
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [OUT_DATA_W-1:0] rsp_tdata,   // scaled_sample, servo_angle,
                                              // duty_count, half_period_ticks
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [2:0]            csr_index,
   input  logic [15:0]           csr_data
);

   localparam int SW = SAMPLE_BITS;
   localparam logic [SW-1:0] FULL_SCALE = '1;
   localparam int DIV_CNT_W = $clog2(asp_pkg::DIV_STEPS + 1);

   // configuration
   logic [SW-1:0] raw_min_ff, raw_max_ff, mid_ff, dz_ff;
   logic [8:0]    alpha_ff;
   logic [15:0]   steps_ff, freq_ff;

   // sequencer
   asp_pkg::step_type  step_ff, step_in;
   asp_pkg::ucode_type uc;
   logic               cond_true;

   // datapath
   logic [SW-1:0]                raw_ff, scaled_ff, dead_ff;
   logic [asp_pkg::ANGLE_W-1:0]  fresh_ff, angle_ff;
   logic [asp_pkg::DUTY_W-1:0]   lo_ff, duty_ff;
   logic [asp_pkg::TICKS_W-1:0]  ticks_ff;
   logic [16:0]                  acc_ff;
   logic [2*asp_pkg::MUL_W-1:0]  prod_ff;
   logic [asp_pkg::MUL_W-1:0]    mul_a, mul_b;
   logic                         mul_en;

   // divider
   logic [asp_pkg::DIV_W-1:0]     quo_ff, div_dividend;
   logic [asp_pkg::DIVISOR_W-1:0] rem_ff, div_divisor, dsr_ff;
   logic [DIV_CNT_W-1:0]          div_cnt_ff;
   logic                          div_busy_ff, div_start;
   logic [asp_pkg::DIVISOR_W:0]   r1, r1s, r2, r2s;
   logic                          q1, q0;

   // output register
   logic                  rsp_valid_ff;
   logic [OUT_DATA_W-1:0] rsp_data_ff;

   // derived values
   logic [SW-1:0]               den;
   logic                        out_of_range, in_band;
   logic [8:0]                  a_eff, a_rest;
   logic [16:0]                 ang_sum;
   logic [asp_pkg::ANGLE_W-1:0] ang_new;
   logic [asp_pkg::DUTY_W-1:0]  duty_hi;
   logic [asp_pkg::DIV_W-2:0]   tick_full;
   logic                        rsp_blocked;

   assign csr_ready  = 1'b1;
   assign uc         = asp_pkg::UCODE_ROM[step_ff];
   assign req_tready = (uc.op == asp_pkg::OP_ACCEPT);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign den          = raw_max_ff - raw_min_ff;
   assign out_of_range = (raw_max_ff <= raw_min_ff) || (raw_ff <= raw_min_ff)
                         || (raw_ff >= raw_max_ff);
   // signed band test mid-dz < v < mid+dz, rearranged so nothing goes negative
   assign in_band = ({1'b0, scaled_ff} + {1'b0, dz_ff} > {1'b0, mid_ff})
                    && ({1'b0, scaled_ff} < {1'b0, mid_ff} + {1'b0, dz_ff});
   assign a_eff   = (alpha_ff > asp_pkg::ALPHA_ONE) ? asp_pkg::ALPHA_ONE : alpha_ff;
   assign a_rest  = asp_pkg::ALPHA_ONE - a_eff;
   assign ang_sum = acc_ff + prod_ff[16:0];
   assign ang_new = (ang_sum[16:8] > 9'(asp_pkg::MAX_DEG)) ? asp_pkg::MAX_DEG
                                                          : ang_sum[15:8];
   assign duty_hi   = asp_pkg::DUTY_W'(steps_ff / asp_pkg::DUTY_HI_DIV);
   assign tick_full = quo_ff[asp_pkg::DIV_W-1:1];
   assign rsp_blocked = rsp_valid_ff && !rsp_tready;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         raw_min_ff <= SW'(7);
         raw_max_ff <= SW'(900);
         mid_ff     <= SW'(450);
         dz_ff      <= SW'(20);
         alpha_ff   <= asp_pkg::ALPHA_RESET;
         steps_ff   <= asp_pkg::STEPS_RESET;
         freq_ff    <= asp_pkg::FREQ_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            asp_pkg::REG_RAW_MIN:   raw_min_ff <= csr_data[SW-1:0];
            asp_pkg::REG_RAW_MAX:   raw_max_ff <= csr_data[SW-1:0];
            asp_pkg::REG_MID_POINT: mid_ff     <= csr_data[SW-1:0];
            asp_pkg::REG_DEADZONE:  dz_ff      <= csr_data[SW-1:0];
            asp_pkg::REG_ALPHA:     alpha_ff   <= csr_data[8:0];
            asp_pkg::REG_STEPS:     steps_ff   <= csr_data;
            asp_pkg::REG_FREQ:      freq_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   // step counter
   always_comb begin
      unique case (uc.cond)
         asp_pkg::COND_NEXT:        cond_true = 1'b0;
         asp_pkg::COND_ALWAYS:      cond_true = 1'b1;
         asp_pkg::COND_NO_REQ:      cond_true = !req_tvalid;
         asp_pkg::COND_CLAMPED:     cond_true = out_of_range;
         asp_pkg::COND_DIV_BUSY:    cond_true = div_busy_ff;
         asp_pkg::COND_NO_TICKS:    cond_true = (steps_ff == '0) || (freq_ff == '0);
         asp_pkg::COND_RSP_BLOCKED: cond_true = rsp_blocked;
         default:                   cond_true = 1'b1;
      endcase
      step_in = cond_true ? uc.target : step_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= asp_pkg::STEP_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

   // operand selection for the shared multiplier and divider
   always_comb begin
      mul_en       = 1'b0;
      mul_a        = '0;
      mul_b        = '0;
      div_start    = 1'b0;
      div_dividend = prod_ff;
      div_divisor  = freq_ff;
      unique case (uc.op)
         asp_pkg::OP_MUL_REMAP: begin
            mul_en = 1'b1;
            mul_a  = asp_pkg::MUL_W'(raw_ff - raw_min_ff);
            mul_b  = asp_pkg::MUL_W'(FULL_SCALE);
         end
         asp_pkg::OP_MUL_FRESH: begin
            mul_en = 1'b1;
            mul_a  = asp_pkg::MUL_W'(dead_ff);
            mul_b  = asp_pkg::MUL_W'(asp_pkg::MAX_DEG);
         end
         asp_pkg::OP_MUL_PREV: begin
            mul_en = 1'b1;
            mul_a  = asp_pkg::MUL_W'(angle_ff);
            mul_b  = asp_pkg::MUL_W'(a_rest);
         end
         asp_pkg::OP_MUL_NEW: begin
            mul_en = 1'b1;
            mul_a  = asp_pkg::MUL_W'(fresh_ff);
            mul_b  = asp_pkg::MUL_W'(a_eff);
         end
         asp_pkg::OP_MUL_DUTY: begin
            mul_en = 1'b1;
            mul_a  = asp_pkg::MUL_W'(duty_hi - lo_ff);
            mul_b  = asp_pkg::MUL_W'(angle_ff);
         end
         asp_pkg::OP_DIV_REMAP: begin
            div_start   = 1'b1;
            div_divisor = asp_pkg::DIVISOR_W'(den);
         end
         asp_pkg::OP_DIV_FRESH: begin
            div_start   = 1'b1;
            div_divisor = asp_pkg::DIVISOR_W'(FULL_SCALE);
         end
         asp_pkg::OP_DIV_LO: begin
            div_start    = 1'b1;
            div_dividend = asp_pkg::DIV_W'(steps_ff);
            div_divisor  = asp_pkg::DIVISOR_W'(asp_pkg::DUTY_LO_DIV);
         end
         asp_pkg::OP_DIV_DUTY: begin
            div_start   = 1'b1;
            div_divisor = asp_pkg::DIVISOR_W'(asp_pkg::MAX_DEG);
         end
         asp_pkg::OP_DIV_T1: begin
            div_start    = 1'b1;
            div_dividend = asp_pkg::DIV_W'(CLOCK_HZ);
            div_divisor  = freq_ff;
         end
         asp_pkg::OP_DIV_T2: begin
            div_start    = 1'b1;
            div_dividend = quo_ff;
            div_divisor  = steps_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mul_en) begin
         prod_ff <= mul_a * mul_b;
      end
   end

   // divider: two restoring steps per cycle
   always_comb begin
      r1  = {rem_ff, quo_ff[asp_pkg::DIV_W-1]};
      q1  = (r1 >= {1'b0, dsr_ff});
      r1s = q1 ? r1 - {1'b0, dsr_ff} : r1;
      r2  = {r1s[asp_pkg::DIVISOR_W-1:0], quo_ff[asp_pkg::DIV_W-2]};
      q0  = (r2 >= {1'b0, dsr_ff});
      r2s = q0 ? r2 - {1'b0, dsr_ff} : r2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_busy_ff <= 1'b0;
         div_cnt_ff  <= '0;
      end else if (div_start) begin
         div_busy_ff <= 1'b1;
         div_cnt_ff  <= DIV_CNT_W'(asp_pkg::DIV_STEPS);
      end else if (div_busy_ff) begin
         div_busy_ff <= (div_cnt_ff != DIV_CNT_W'(1));
         div_cnt_ff  <= div_cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (div_start) begin
         rem_ff <= '0;
         quo_ff <= div_dividend;
         dsr_ff <= div_divisor;
      end else if (div_busy_ff) begin
         rem_ff <= r2s[asp_pkg::DIVISOR_W-1:0];
         quo_ff <= {quo_ff[asp_pkg::DIV_W-3:0], q1, q0};
      end
   end

   // filtered angle is state and resets; the rest is scratch
   always_ff @(posedge clock) begin
      if (reset) begin
         angle_ff <= asp_pkg::ANGLE_RESET;
      end else if (uc.op == asp_pkg::OP_SET_ANGLE) begin
         angle_ff <= ang_new;
      end
   end

   always_ff @(posedge clock) begin
      unique case (uc.op)
         asp_pkg::OP_ACCEPT:     raw_ff    <= req_tdata[SW-1:0];
         asp_pkg::OP_CLAMP:      scaled_ff <= ((raw_max_ff <= raw_min_ff)
                                               || (raw_ff <= raw_min_ff)) ? '0 : FULL_SCALE;
         asp_pkg::OP_SET_SCALED: scaled_ff <= quo_ff[SW-1:0];
         asp_pkg::OP_SNAP:       dead_ff   <= in_band ? mid_ff : scaled_ff;
         asp_pkg::OP_SET_FRESH:  fresh_ff  <= quo_ff[asp_pkg::ANGLE_W-1:0];
         asp_pkg::OP_MUL_NEW:    acc_ff    <= prod_ff[16:0];
         asp_pkg::OP_SET_LO:     lo_ff     <= quo_ff[asp_pkg::DUTY_W-1:0];
         asp_pkg::OP_SET_DUTY:   duty_ff   <= lo_ff + quo_ff[asp_pkg::DUTY_W-1:0];
         asp_pkg::OP_ZERO_TICKS: ticks_ff  <= '0;
         asp_pkg::OP_SET_TICKS:  ticks_ff  <= (|tick_full[asp_pkg::DIV_W-2:asp_pkg::TICKS_W])
                                              ? '1 : tick_full[asp_pkg::TICKS_W-1:0];
         default: ;
      endcase
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (uc.op == asp_pkg::OP_EMIT && !rsp_blocked) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (uc.op == asp_pkg::OP_EMIT && !rsp_blocked) begin
         rsp_data_ff <= OUT_DATA_W'({ticks_ff, duty_ff, angle_ff, scaled_ff});
      end
   end

endmodule

// ===== sv/asp_checker.sv =====
// Port-level checks for the ADC-to-servo PWM mapper, bound to its top level.
// Depends on adc_to_servo_pwm_mapper_top.
module asp_checker #(
   parameter int OUT_DATA_W = 64
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [OUT_DATA_W-1:0] rsp_tdata
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat changed while stalled");

   // a sample in work blocks the input
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input ready right after a sample was taken");

   // a new result comes out of the last program step, never from idle
   a_result_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tready))
      else $error("result appeared while the block was idle");

   a_reset_state: assert property (@(posedge clock)
      reset |=> req_tready && !rsp_tvalid)
      else $error("block not idle and empty after reset");

endmodule

bind adc_to_servo_pwm_mapper_top asp_checker #(
   .OUT_DATA_W(OUT_DATA_W)
) u_asp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
